@@ sv/nhc_pkg.sv @@
package nhc_pkg;

    // One finished name waiting for the color stage.
    typedef struct packed {
        logic [31:0] hash;
        logic        light_mode;
    } t_job;

    // Push side of the queue, driven by the front end.
    typedef struct packed {
        logic push;
        t_job job;
    } t_front_out;

    localparam logic [7:0] TOP_DARK_TEXT  = 8'hF8;
    localparam logic [7:0] TOP_LIGHT_TEXT = 8'h50;
    localparam logic [7:0] LEVEL_GAP      = 8'h20;

    // Reciprocals for dividing by six (shift 34) and by ten (shift 35).
    localparam logic [31:0] RECIP_SEXTANT = 32'hAAAAAAAB;
    localparam logic [31:0] RECIP_DIGIT   = 32'hCCCCCCCD;

endpackage

@@ sv/nhc_front.sv @@
module nhc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_name_byte,
    input  logic                i_last_byte,
    input  logic                i_queue_full,
    output nhc_pkg::t_front_out o_front
);

    logic        r_light_mode;
    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic        w_accept;

    // The input is held back only while the queue cannot take a name.
    assign o_in_stall = i_queue_full;
    assign w_accept   = i_in_valid && !i_queue_full;

    // Shift and xor hash step with the byte zero-extended.
    assign n_hash = (r_hash << 11) ^ (r_hash << 1) ^ (r_hash >> 3) ^ {24'd0, i_name_byte};

    // Hash register, cleared after the last byte of each name.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash       <= '0;
            r_light_mode <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_light_mode <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_hash <= i_last_byte ? 32'd0 : n_hash;
            end
        end
    end

    // A finished name goes to the queue together with the text mode.
    assign o_front.push           = w_accept && i_last_byte;
    assign o_front.job.hash       = n_hash;
    assign o_front.job.light_mode = r_light_mode;

endmodule

@@ sv/nhc_queue.sv @@
module nhc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nhc_pkg::t_front_out i_front,
    output logic                o_full,
    output logic                o_not_empty,
    input  logic                i_pop,
    output nhc_pkg::t_job       o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nhc_pkg::t_job    r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign w_push      = i_front.push && !o_full;
    assign w_pop       = i_pop && o_not_empty;
    assign o_job       = r_slot[r_rd_ptr];

    // Storage slots, written at the write pointer.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_front.job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ sv/nhc_back.sv @@
module nhc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  nhc_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_red,
    output logic [7:0]    o_green,
    output logic [7:0]    o_blue
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RECIP,
        S_MOD,
        S_EMIT
    } t_state;

    t_state      r_state;
    logic [1:0]  r_phase;
    logic [4:0]  r_bit;
    logic [31:0] r_quo;
    logic [5:0]  r_rem;
    logic        r_light_mode;
    logic [2:0]  r_sextant;
    logic [3:0]  r_digit1;
    logic [3:0]  r_digit2;
    logic [5:0]  r_rest_mod;
    logic        r_out_valid;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;

    logic [31:0] w_recip;
    logic [63:0] w_prod;
    logic [31:0] w_q;
    logic [3:0]  w_q_times;
    logic [3:0]  w_small_rem;
    logic [5:0]  w_divisor;
    logic [6:0]  w_rem_shift;
    logic [6:0]  w_diff;
    logic        w_qbit;
    logic [5:0]  n_rem;
    logic [7:0]  w_top;
    logic [7:0]  w_bottom;
    logic [7:0]  w_middle;
    logic        w_out_free;

    // Reciprocal multiply: the sextant pass divides by six, the digit passes by ten.
    assign w_recip = (r_phase == 2'd0) ? nhc_pkg::RECIP_SEXTANT : nhc_pkg::RECIP_DIGIT;
    assign w_prod  = 64'(r_quo) * 64'(w_recip);
    assign w_q     = (r_phase == 2'd0) ? {2'b00, w_prod[63:34]} : {3'b000, w_prod[63:35]};

    // The remainder fits in four bits, so only the low bits of quotient times divisor count.
    assign w_q_times   = (r_phase == 2'd0) ? ({w_q[2:0], 1'b0} + {w_q[1:0], 2'b00})
                                           : ({w_q[2:0], 1'b0} + {w_q[0], 3'b000});
    assign w_small_rem = r_quo[3:0] - w_q_times;

    // The level span depends on the second digit, so it uses a serial remainder.
    assign w_divisor = {2'b00, r_digit2} + nhc_pkg::LEVEL_GAP[5:0];

    // One restoring division step per cycle.
    assign w_rem_shift = {r_rem, r_quo[31]};
    assign w_diff      = w_rem_shift - {1'b0, w_divisor};
    assign w_qbit      = (w_rem_shift >= {1'b0, w_divisor});
    assign n_rem       = w_qbit ? w_diff[5:0] : w_rem_shift[5:0];

    // Levels from the two digits and the last remainder.
    assign w_top    = (r_light_mode ? nhc_pkg::TOP_LIGHT_TEXT : nhc_pkg::TOP_DARK_TEXT)
                      - {4'd0, r_digit1};
    assign w_bottom = w_top - {4'd0, r_digit2} - nhc_pkg::LEVEL_GAP;
    assign w_middle = {2'b00, r_rest_mod} + w_bottom;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = (r_state == S_IDLE) && i_job_valid;

    // Sequencer, divider registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_bit       <= '0;
        end else begin
            // The output register is loaded on emit and cleared once taken.
            if ((r_state == S_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_quo        <= i_job.hash;
                        r_light_mode <= i_job.light_mode;
                        r_phase      <= '0;
                        r_state      <= S_RECIP;
                    end
                end
                S_RECIP: begin
                    // Keep the remainder, divide the quotient next.
                    r_quo   <= w_q;
                    r_phase <= r_phase + 1'b1;
                    case (r_phase)
                        2'd0:    r_sextant <= w_small_rem[2:0];
                        2'd1:    r_digit1  <= w_small_rem;
                        default: r_digit2  <= w_small_rem;
                    endcase
                    if (r_phase == 2'd2) begin
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_quo <= {r_quo[30:0], w_qbit};
                    r_rem <= n_rem;
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == 5'd31) begin
                        r_rest_mod <= n_rem;
                        r_state    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        case (r_sextant)
                            3'd0: begin
                                r_red <= w_top;    r_green <= w_middle; r_blue <= w_bottom;
                            end
                            3'd1: begin
                                r_red <= w_middle; r_green <= w_top;    r_blue <= w_bottom;
                            end
                            3'd2: begin
                                r_red <= w_bottom; r_green <= w_top;    r_blue <= w_middle;
                            end
                            3'd3: begin
                                r_red <= w_bottom; r_green <= w_middle; r_blue <= w_top;
                            end
                            3'd4: begin
                                r_red <= w_middle; r_green <= w_bottom; r_blue <= w_top;
                            end
                            default: begin
                                r_red <= w_top;    r_green <= w_bottom; r_blue <= w_middle;
                            end
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;

endmodule

@@ sv/name_hash_to_color.sv @@
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-----------------------------------
// input    | i_in_valid / o_in_stall    | i_name_byte, i_last_byte
// output   | o_out_valid / i_out_stall  | o_red, o_green, o_blue
// config   | i_cfg_wr_en                | i_cfg_wr_data (light text mode)
//
// Name bytes are taken one per cycle while the queue has room; each one updates the hash.
// The color stage takes one name at a time: a load, three reciprocal multiplies
// for the sextant and two digits, a 32-step serial remainder for the middle level, an emit.
// The input stalls only while the name queue is full.
// Reset is synchronous and active low; it clears the hash, mode, queue and output valid.
// A stalled output holds its color and the color stage waits behind it.
module name_hash_to_color #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_name_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    nhc_pkg::t_front_out w_front;
    nhc_pkg::t_job       w_job;
    logic                w_full;
    logic                w_not_empty;
    logic                w_pop;

    // Front end: hashes bytes and hands off finished names.
    nhc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_name_byte   (i_name_byte),
        .i_last_byte   (i_last_byte),
        .i_queue_full  (w_full),
        .o_front       (w_front)
    );

    // Queue of finished hashes between the two halves.
    nhc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_front     (w_front),
        .o_full      (w_full),
        .o_not_empty (w_not_empty),
        .i_pop       (w_pop),
        .o_job       (w_job)
    );

    // Back end: splits the hash and builds the color.
    nhc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_not_empty),
        .i_job       (w_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

endmodule

@@ sv/nhc_checker.sv @@
module nhc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);

    // A color offered under stall stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled color does not change.
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_red) && $stable(o_green) && $stable(o_blue))
        else $error("output color changed while stalled");

    // Reset leaves no color pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Every level lies between the lowest bottom and the highest top.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_red >= 8'd30 && o_red <= 8'd248
                     && o_green >= 8'd30 && o_green <= 8'd248
                     && o_blue >= 8'd30 && o_blue <= 8'd248)
        else $error("color level out of range");

endmodule

bind name_hash_to_color nhc_checker u_nhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_red       (o_red),
    .o_green     (o_green),
    .o_blue      (o_blue)
);

@@ dv/name_hash_to_color_tb.sv @@
module name_hash_to_color_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLOR_LATENCY  = 38;
    localparam int SETTLE_CYCLES  = COLOR_LATENCY + 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 120;

    // Order in which top, middle and bottom land on red, green and blue.
    typedef enum int unsigned {
        ARR_TMB,
        ARR_MTB,
        ARR_BTM,
        ARR_BMT,
        ARR_MBT,
        ARR_TBM
    } t_arrangement;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_name_byte   = 8'h00;
    logic       i_last_byte   = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall   = 1'b0;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;

    // Mirror of the block state, updated at each accepted transfer.
    logic [31:0] hash_now       = '0;
    logic        light_mode_now = 1'b0;
    t_rgb        colors_due[$];

    int  mismatches     = 0;
    int  bytes_sent     = 0;
    int  quiet_cycles   = 0;
    int  stall_left     = 0;
    bit  sender_gaps_on = 1'b0;
    bit  sink_stalls_on = 1'b0;

    name_hash_to_color u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_name_byte   (i_name_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // One round of the running hash; the byte is zero-extended.
    function automatic logic [31:0] fold_byte(logic [31:0] h, logic [7:0] b);
        return (h << 11) ^ (h << 1) ^ (h >> 3) ^ {24'd0, b};
    endfunction

    // Color of a finished name from its final hash and the text mode.
    function automatic t_rgb name_color(logic [31:0] h, logic light);
        t_rgb         c;
        t_arrangement arr;
        logic [31:0]  q;
        logic [7:0]   d1;
        logic [7:0]   d2;
        logic [7:0]   top;
        logic [7:0]   bottom;
        logic [7:0]   middle;
        arr = t_arrangement'(h % 32'd6);
        q = h / 32'd6;
        d1 = 8'(q % 32'd10);
        q = q / 32'd10;
        d2 = 8'(q % 32'd10);
        q = q / 32'd10;
        top = (light ? nhc_pkg::TOP_LIGHT_TEXT : nhc_pkg::TOP_DARK_TEXT) - d1;
        bottom = top - d2 - nhc_pkg::LEVEL_GAP;
        middle = 8'(q % (32'(d2) + 32'(nhc_pkg::LEVEL_GAP))) + bottom;
        case (arr)
            ARR_TMB: c = '{top, middle, bottom};
            ARR_MTB: c = '{middle, top, bottom};
            ARR_BTM: c = '{bottom, top, middle};
            ARR_BMT: c = '{bottom, middle, top};
            ARR_MBT: c = '{middle, bottom, top};
            default: c = '{top, bottom, middle};
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Send one byte, called at a falling edge; returns at the falling edge after it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_name_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_in_stall);
        if (last) begin
            colors_due.push_back(name_color(fold_byte(hash_now, b), light_mode_now));
            hash_now = '0;
        end else begin
            hash_now = fold_byte(hash_now, b);
        end
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Mostly short names, now and then a long one.
    task automatic send_random_name();
        int len;
        if ($urandom_range(0, 15) == 0) begin
            len = $urandom_range(20, 48);
        end else begin
            len = $urandom_range(1, 8);
        end
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // Hold the input idle until every expected color is out, then optionally settle.
    task automatic wait_colors_drained(input bit settle);
        i_in_valid <= 1'b0;
        while (colors_due.size() != 0) @(negedge i_clk);
        if (settle) begin
            repeat (SETTLE_CYCLES) @(negedge i_clk);
        end
    endtask

    // The mode register is written only while the block is idle.
    task automatic set_light_mode(input logic light);
        wait_colors_drained(1'b1);
        i_cfg_wr_en    <= 1'b1;
        i_cfg_wr_data  <= light;
        light_mode_now = light;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input int n_bytes, input logic light);
        int target;
        set_light_mode(light);
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) send_random_name();
    endtask

    // Single-byte names at the byte extremes, in the reset mode.
    task automatic test_one_byte_names();
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'hFE, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    // Zero bytes are hashed like any other and do not end a name.
    task automatic test_zero_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h42, 1'b1);
    endtask

    task automatic test_light_text_mode();
        set_light_mode(1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        set_light_mode(1'b0);
    endtask

    // The sender stops until the color stage has emptied, then resumes.
    task automatic test_sender_pause();
        repeat (10) send_random_name();
        wait_colors_drained(1'b0);
        repeat (10) send_random_name();
    endtask

    task automatic test_random_names();
        for (int p = 0; p < 5; p++) begin
            random_phase(PHASE_BYTES, p[0]);
        end
    endtask

    task automatic test_no_idling();
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        random_phase(PHASE_BYTES, 1'b1);
    endtask

    // Output stall in random bursts.
    always @(negedge i_clk) begin
        if (!sink_stalls_on) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each color transfer with the oldest expected color.
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (colors_due.size() == 0) begin
                report_mismatch($sformatf("unexpected color %02h %02h %02h",
                                          o_red, o_green, o_blue));
            end else begin
                want = colors_due.pop_front();
                if (o_red !== want.red) begin
                    report_mismatch($sformatf("red %02h, expected %02h", o_red, want.red));
                end
                if (o_green !== want.green) begin
                    report_mismatch($sformatf("green %02h, expected %02h",
                                              o_green, want.green));
                end
                if (o_blue !== want.blue) begin
                    report_mismatch($sformatf("blue %02h, expected %02h", o_blue, want.blue));
                end
            end
        end
    end

    // End the run if no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired at %0t ns with %0d colors outstanding",
                         $time, colors_due.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_one_byte_names();
        test_zero_bytes();
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        test_light_text_mode();
        test_sender_pause();
        test_random_names();
        test_no_idling();

        wait_colors_drained(1'b1);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
